FILE: design/gpda_pkg.sv
// ----------------------------------------------------------------------------
// gpda_pkg
// Shared widths, register codes and control structs of the grid acceptance
// block.
// ----------------------------------------------------------------------------
package gpda_pkg;

	localparam int SIDE_W  = 7;
	localparam int CS_W    = 16;
	localparam int IDX_W   = 12;
	localparam int OFF_W   = 16;
	localparam int POS_W   = 22;
	localparam int CNT_W   = 13;
	localparam int LIM_W   = 2 * CS_W;
	localparam int SQ_W    = 2 * POS_W + 1;
	localparam int CELL_W  = 2 * SIDE_W;
	localparam int PROD_W  = SIDE_W + CS_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IN_W    = 48;
	localparam int OUT_W   = 72;

	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 2'd1;

	localparam logic [1:0] PROBE_LAST = 2'd2;
	localparam logic [1:0] PROBE_MID  = 2'd1;

	typedef struct packed {
		logic              start;
		logic [IDX_W-1:0]  idx;
		logic [SIDE_W-1:0] row;
		logic [SIDE_W-1:0] col;
		logic [SIDE_W-1:0] side;
		logic [POS_W-1:0]  px;
		logic [POS_W-1:0]  py;
		logic [LIM_W-1:0]  lim;
	} probe_cmd_t;

	typedef struct packed {
		logic ready;
		logic done;
		logic near;
		logic own_occ;
	} probe_sts_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [POS_W-1:0] px;
		logic [POS_W-1:0] py;
	} grid_wr_t;

endpackage

FILE: design/gpda_ram.sv
// ----------------------------------------------------------------------------
// gpda_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gpda_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/gpda_div.sv
// ----------------------------------------------------------------------------
// gpda_div
// Restoring divider, one quotient bit per cycle, splits a cell index into
// row and column.
// ----------------------------------------------------------------------------
module gpda_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [gpda_pkg::IDX_W-1:0]  dividend,
	input  logic [gpda_pkg::SIDE_W-1:0] divisor,
	output logic                       done,
	output logic [gpda_pkg::IDX_W-1:0]  quotient,
	output logic [gpda_pkg::SIDE_W-1:0] remainder
);

	localparam int IW = gpda_pkg::IDX_W;
	localparam int SW = gpda_pkg::SIDE_W;
	localparam int CW = $clog2(IW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] quo_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] div_q;

	logic [SW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[IW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(IW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[IW-2:0], fits};
			rem_q <= fits ? SW'(trial - {1'b0, div_q}) : SW'(trial);
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: design/gpda_grid.sv
// ----------------------------------------------------------------------------
// gpda_grid
// Occupancy and position memories, clearing pass after reset, and the
// neighborhood probe pipeline that reads nine cells and tests spacing.
// ----------------------------------------------------------------------------
module gpda_grid #(
	parameter int MAX_SIDE = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gpda_pkg::probe_cmd_t  cmd,
	input  gpda_pkg::grid_wr_t    wr,
	output gpda_pkg::probe_sts_t  sts
);

	localparam int DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = gpda_pkg::SIDE_W;
	localparam int PW    = gpda_pkg::POS_W;
	localparam int CLW   = gpda_pkg::CELL_W;
	localparam int SQW   = gpda_pkg::SQ_W;

	// clearing pass
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	// probe sequencing
	logic       run_q;
	logic [1:0] kr_q;
	logic [1:0] kc_q;
	logic       last_k;

	logic [SW:0]    rp;
	logic [SW:0]    cp;
	logic           inb;
	logic [SW-1:0]  r2;
	logic [SW-1:0]  c2;
	logic [CLW-1:0] rprod;
	logic [CLW-1:0] ncell;

	logic vld_s1, inb_s1, self_s1, last_s1;
	logic chk_s2, last_s2;
	logic chk_s3, last_s3;
	logic [PW-1:0]  dx_s2, dy_s2;
	logic [2*PW-1:0] sqx_s3, sqy_s3;
	logic [SQW-1:0] dist2;
	logic           hit;
	logic near_q, own_q, done_q;

	// memory ports
	logic           occ_we;
	logic [AW-1:0]  occ_waddr;
	logic           occ_wdata;
	logic           occ_rd;
	logic [2*PW-1:0] pos_rd;
	logic [PW-1:0]  nx, ny;

	assign occ_we    = clr_q | wr.en;
	assign occ_waddr = clr_q ? clr_addr_q : AW'(wr.idx);
	assign occ_wdata = ~clr_q;

	gpda_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_occ (
		.clk   (clk),
		.we    (occ_we),
		.waddr (occ_waddr),
		.wdata (occ_wdata),
		.raddr (AW'(ncell)),
		.rdata (occ_rd)
	);

	gpda_ram #(.WIDTH(2 * PW), .DEPTH(DEPTH)) u_pos (
		.clk   (clk),
		.we    (wr.en),
		.waddr (AW'(wr.idx)),
		.wdata ({wr.py, wr.px}),
		.raddr (AW'(ncell)),
		.rdata (pos_rd)
	);

	assign nx = pos_rd[PW-1:0];
	assign ny = pos_rd[2*PW-1:PW];

	// neighbor address, row + kr - 1 and col + kc - 1
	assign rp     = {1'b0, cmd.row} + (SW + 1)'(kr_q);
	assign cp     = {1'b0, cmd.col} + (SW + 1)'(kc_q);
	assign inb    = (rp != '0) && (rp <= {1'b0, cmd.side}) &&
	                (cp != '0) && (cp <= {1'b0, cmd.side});
	assign r2     = SW'(rp - 1'b1);
	assign c2     = SW'(cp - 1'b1);
	assign rprod  = r2 * cmd.side;
	assign ncell  = rprod + CLW'(c2);
	assign last_k = (kr_q == gpda_pkg::PROBE_LAST) && (kc_q == gpda_pkg::PROBE_LAST);

	assign dist2 = SQW'(sqx_s3) + SQW'(sqy_s3);
	assign hit   = dist2 < SQW'(cmd.lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			run_q      <= 1'b0;
			kr_q       <= '0;
			kc_q       <= '0;
			vld_s1     <= 1'b0;
			last_s1    <= 1'b0;
			chk_s2     <= 1'b0;
			last_s2    <= 1'b0;
			chk_s3     <= 1'b0;
			last_s3    <= 1'b0;
			near_q     <= 1'b0;
			own_q      <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					clr_q <= 1'b0;
				end
			end

			if (cmd.start) begin
				run_q  <= 1'b1;
				kr_q   <= '0;
				kc_q   <= '0;
				near_q <= 1'b0;
				own_q  <= 1'b0;
			end else if (run_q) begin
				if (kc_q == gpda_pkg::PROBE_LAST) begin
					kc_q <= '0;
					kr_q <= kr_q + 1'b1;
				end else begin
					kc_q <= kc_q + 1'b1;
				end
				if (last_k) begin
					run_q <= 1'b0;
				end
			end

			vld_s1  <= run_q & ~cmd.start;
			last_s1 <= run_q & ~cmd.start & last_k;

			chk_s2  <= vld_s1 & inb_s1 & ~self_s1 & occ_rd;
			last_s2 <= last_s1;
			if (vld_s1 && self_s1) begin
				own_q <= occ_rd;
			end

			chk_s3  <= chk_s2;
			last_s3 <= last_s2;

			if (chk_s3 && hit) begin
				near_q <= 1'b1;
			end
			done_q <= last_s3;
		end
	end

	always_ff @(posedge clk) begin
		inb_s1  <= inb;
		self_s1 <= (kr_q == gpda_pkg::PROBE_MID) && (kc_q == gpda_pkg::PROBE_MID);
		dx_s2   <= (nx > cmd.px) ? nx - cmd.px : cmd.px - nx;
		dy_s2   <= (ny > cmd.py) ? ny - cmd.py : cmd.py - ny;
		sqx_s3  <= dx_s2 * dx_s2;
		sqy_s3  <= dy_s2 * dy_s2;
	end

	assign sts.ready   = ~clr_q;
	assign sts.done    = done_q;
	assign sts.near    = near_q;
	assign sts.own_occ = own_q;

endmodule

FILE: design/grid_poisson_disk_accept_top.sv
// ----------------------------------------------------------------------------
// grid_poisson_disk_accept_top
// Grid based Poisson disk acceptance of candidate samples. Each word on the
// input stream is a candidate cell and an offset inside it; each word on the
// output stream reports whether it was stored, its absolute position and the
// running sample count. After reset the occupancy memory is swept clear, one
// entry a cycle, over all MAX_SIDE*MAX_SIDE entries (4096 at the default)
// while s_tready stays low; configuration writes are taken during that time.
// An in-range candidate then passes through the bit-serial divider that
// splits the cell index into row and column, position and limit arithmetic,
// nine reads of the occupancy and position memories at a shared read
// address plus a four-stage distance pipeline, and a final write when the
// sample is stored. An out-of-range candidate skips the divider and probe.
// One candidate is in work at a time; a finished result waits in the output
// register while the next candidate is taken.
// ----------------------------------------------------------------------------
module grid_poisson_disk_accept_top #(
	parameter int MAX_SIDE = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// cell_index[11:0], offset_x[27:12], offset_y[43:28]
	input  logic [gpda_pkg::IN_W-1:0]          s_tdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// sample_cell[11:0], sample_x[33:12], sample_y[55:34], accepted_count[68:56]
	output logic [gpda_pkg::OUT_W-1:0]         m_tdata,
	// accepted[0]
	output logic                              m_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gpda_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gpda_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int SW   = gpda_pkg::SIDE_W;
	localparam int CSW  = gpda_pkg::CS_W;
	localparam int IW   = gpda_pkg::IDX_W;
	localparam int OW   = gpda_pkg::OFF_W;
	localparam int PW   = gpda_pkg::POS_W;
	localparam int CNW  = gpda_pkg::CNT_W;
	localparam int LW   = gpda_pkg::LIM_W;
	localparam int CLW  = gpda_pkg::CELL_W;
	localparam int PRW  = gpda_pkg::PROD_W;
	localparam int OUTW = gpda_pkg::OUT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_SUM,
		ST_PROBE,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [SW-1:0]  grid_side_q;
	logic [CSW-1:0] cell_size_q;

	logic [IW-1:0]  idx_q;
	logic [OW-1:0]  offx_q;
	logic [OW-1:0]  offy_q;
	logic [SW-1:0]  side_q;
	logic [SW-1:0]  row_q;
	logic [SW-1:0]  col_q;
	logic [PRW-1:0] prodx_q;
	logic [PRW-1:0] prody_q;
	logic [LW-1:0]  lim_q;
	logic [PW-1:0]  px_q;
	logic [PW-1:0]  py_q;
	logic           acc_q;
	logic [CNW-1:0] cnt_q;
	logic           div_start_q;
	logic           probe_start_q;

	logic           m_tvalid_q;
	logic           m_tuser_q;
	logic [OUTW-1:0] m_tdata_q;

	logic [SW-1:0]  side_c;
	logic [CLW-1:0] ncells_c;
	logic           in_range_c;
	logic           s_accept;
	logic           out_free;
	logic [CNW-1:0] cnt_nxt;
	logic [PRW:0]   sumx;
	logic [PRW:0]   sumy;

	logic           div_done;
	logic [IW-1:0]  div_quo;
	logic [SW-1:0]  div_rem;

	gpda_pkg::probe_cmd_t cmd;
	gpda_pkg::probe_sts_t sts;
	gpda_pkg::grid_wr_t   wr;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= SW'(64);
			cell_size_q <= CSW'(256);
		end else if (cfg_valid) begin
			case (cfg_index)
				gpda_pkg::CFG_GRID_SIDE: grid_side_q <= cfg_data[SW-1:0];
				gpda_pkg::CFG_CELL_SIZE: cell_size_q <= cfg_data[CSW-1:0];
				default: ;
			endcase
		end
	end

	assign side_c     = (int'(grid_side_q) > MAX_SIDE) ? SW'(MAX_SIDE) : grid_side_q;
	assign ncells_c   = side_c * side_c;
	assign in_range_c = (side_c != '0) && (CLW'(s_tdata[IW-1:0]) < ncells_c);

	assign s_tready = (state_q == ST_IDLE) && sts.ready;
	assign s_accept = s_tvalid && s_tready;
	assign out_free = ~m_tvalid_q | m_tready;

	assign cnt_nxt = (acc_q && cnt_q != gpda_pkg::CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
	assign sumx    = {1'b0, prodx_q} + (PRW + 1)'(offx_q);
	assign sumy    = {1'b0, prody_q} + (PRW + 1)'(offy_q);

	gpda_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_q),
		.dividend  (idx_q),
		.divisor   (side_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign cmd.start = probe_start_q;
	assign cmd.idx   = idx_q;
	assign cmd.row   = row_q;
	assign cmd.col   = col_q;
	assign cmd.side  = side_q;
	assign cmd.px    = px_q;
	assign cmd.py    = py_q;
	assign cmd.lim   = lim_q;

	assign wr.en  = (state_q == ST_FIN) && out_free && acc_q;
	assign wr.idx = idx_q;
	assign wr.px  = px_q;
	assign wr.py  = py_q;

	gpda_grid #(.MAX_SIDE(MAX_SIDE)) u_grid (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.wr     (wr),
		.sts    (sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			div_start_q   <= 1'b0;
			probe_start_q <= 1'b0;
			acc_q         <= 1'b0;
			cnt_q         <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			div_start_q   <= 1'b0;
			probe_start_q <= 1'b0;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						if (in_range_c) begin
							div_start_q <= 1'b1;
							state_q     <= ST_DIV;
						end else begin
							acc_q   <= 1'b0;
							state_q <= ST_FIN;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					probe_start_q <= 1'b1;
					state_q       <= ST_PROBE;
				end
				ST_PROBE: begin
					if (sts.done) begin
						acc_q   <= ~sts.near & ~sts.own_occ;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						cnt_q      <= cnt_nxt;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// candidate datapath
	always_ff @(posedge clk) begin
		if (s_accept) begin
			idx_q  <= s_tdata[IW-1:0];
			offx_q <= s_tdata[IW+OW-1:IW];
			offy_q <= s_tdata[IW+2*OW-1:IW+OW];
			side_q <= side_c;
			px_q   <= '0;
			py_q   <= '0;
		end
		if (state_q == ST_DIV && div_done) begin
			row_q <= div_quo[SW-1:0];
			col_q <= div_rem;
		end
		if (state_q == ST_MUL) begin
			prodx_q <= col_q * cell_size_q;
			prody_q <= row_q * cell_size_q;
			lim_q   <= cell_size_q * cell_size_q;
		end
		if (state_q == ST_SUM) begin
			px_q <= (sumx > (PRW + 1)'(gpda_pkg::POS_MAX)) ? gpda_pkg::POS_MAX : PW'(sumx);
			py_q <= (sumy > (PRW + 1)'(gpda_pkg::POS_MAX)) ? gpda_pkg::POS_MAX : PW'(sumy);
		end
		if (state_q == ST_FIN && out_free) begin
			m_tuser_q <= acc_q;
			m_tdata_q <= OUTW'({cnt_nxt, py_q, px_q, idx_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for grid_poisson_disk_accept_top. Candidates go in on
// the slave stream in bursts with random gaps while the master side stalls
// on its own pattern. A local model of the occupancy grid predicts every
// result word, which is compared field by field as it leaves the block. The
// run covers the reset settings, small and empty grids, out-of-range cells,
// an oversized side, zero and maximum cell sizes, and random mixes of
// in-cell, neighbour-seeking and arbitrary candidates under ten settings.
// ----------------------------------------------------------------------------
module testbench;

	localparam int SIDE_W     = gpda_pkg::SIDE_W;
	localparam int CS_W       = gpda_pkg::CS_W;
	localparam int IDX_W      = gpda_pkg::IDX_W;
	localparam int OFF_W      = gpda_pkg::OFF_W;
	localparam int POS_W      = gpda_pkg::POS_W;
	localparam int CNT_W      = gpda_pkg::CNT_W;
	localparam int CFG_IDX_W  = gpda_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = gpda_pkg::CFG_DATA_W;
	localparam int IN_W       = gpda_pkg::IN_W;
	localparam int OUT_W      = gpda_pkg::OUT_W;

	localparam logic [POS_W-1:0] POS_MAX = gpda_pkg::POS_MAX;
	localparam logic [CNT_W-1:0] CNT_MAX = gpda_pkg::CNT_MAX;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE = gpda_pkg::CFG_GRID_SIDE;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = gpda_pkg::CFG_CELL_SIZE;

	localparam int GRID_MAX   = 64;
	localparam int GRID_CELLS = GRID_MAX * GRID_MAX;

	typedef struct packed {
		logic              accepted;
		logic [IDX_W-1:0]  cell_id;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [CNT_W-1:0]  count;
	} sample_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic [IN_W-1:0]       s_tdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [OUT_W-1:0]      m_tdata;
	logic                  m_tuser;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// model of the grid
	logic [SIDE_W-1:0] side_reg = 7'd64;
	logic [CS_W-1:0]   size_reg = 16'd256;
	bit                occupied_map [GRID_CELLS];
	logic [POS_W-1:0]  stored_x [GRID_CELLS];
	logic [POS_W-1:0]  stored_y [GRID_CELLS];
	logic [CNT_W-1:0]  accepted_total = '0;
	int                last_stored_cell = 0;

	sample_t expected_samples [$];

	int errors = 0;
	int candidates_sent = 0;
	int out_of_range_count = 0;
	int register_writes = 0;

	int unsigned stall_left = 0;
	rx_mode_t    stall_mode = RX_OPEN;

	grid_poisson_disk_accept_top #(
		.MAX_SIDE(GRID_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic sample_t judge_candidate(input logic [IDX_W-1:0] idx,
			input logic [OFF_W-1:0] offx, input logic [OFF_W-1:0] offy);
		sample_t res;
		bit [63:0] side, col, row, lim, ax, ay, ddx, ddy;
		int r2, c2, n;
		bit near;
		res = '0;
		res.cell_id = idx;
		near = 1'b0;
		side = (side_reg > GRID_MAX) ? 64'(GRID_MAX) : 64'(side_reg);
		if (side != 0 && 64'(idx) < side * side) begin
			col = 64'(idx) % side;
			row = 64'(idx) / side;
			lim = 64'(size_reg) * 64'(size_reg);
			ax = col * 64'(size_reg) + 64'(offx);
			ay = row * 64'(size_reg) + 64'(offy);
			if (ax > 64'(POS_MAX))
				ax = 64'(POS_MAX);
			if (ay > 64'(POS_MAX))
				ay = 64'(POS_MAX);
			for (int dr = -1; dr <= 1; dr++) begin
				for (int dc = -1; dc <= 1; dc++) begin
					if (dr == 0 && dc == 0)
						continue;
					r2 = int'(row) + dr;
					c2 = int'(col) + dc;
					if (r2 < 0 || c2 < 0 || r2 >= int'(side) || c2 >= int'(side))
						continue;
					n = r2 * int'(side) + c2;
					if (!occupied_map[n])
						continue;
					ddx = (64'(stored_x[n]) > ax) ? 64'(stored_x[n]) - ax : ax - 64'(stored_x[n]);
					ddy = (64'(stored_y[n]) > ay) ? 64'(stored_y[n]) - ay : ay - 64'(stored_y[n]);
					if (ddx * ddx + ddy * ddy < lim)
						near = 1'b1;
				end
			end
			if (!near && !occupied_map[idx]) begin
				occupied_map[idx] = 1'b1;
				stored_x[idx] = ax[POS_W-1:0];
				stored_y[idx] = ay[POS_W-1:0];
				last_stored_cell = int'(idx);
				if (accepted_total != CNT_MAX)
					accepted_total = accepted_total + 1'b1;
				res.accepted = 1'b1;
			end
			res.x = ax[POS_W-1:0];
			res.y = ay[POS_W-1:0];
		end else begin
			out_of_range_count++;
		end
		res.count = accepted_total;
		return res;
	endfunction

	// call right after a rising edge; valid stays high on return
	task automatic offer_candidate(input logic [IDX_W-1:0] idx, input logic [OFF_W-1:0] offx,
			input logic [OFF_W-1:0] offy);
		s_tdata <= {{(IN_W - IDX_W - 2 * OFF_W){1'b0}}, offy, offx, idx};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		expected_samples.push_back(judge_candidate(idx, offx, offy));
		candidates_sent++;
	endtask

	task automatic pause_sender(input int unsigned cycles);
		if (cycles != 0) begin
			s_tvalid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] side_word,
			input logic [CFG_DATA_W-1:0] size_word, input bit with_spares);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_GRID_SIDE;
		cfg_data <= side_word;
		do @(posedge clk); while (!cfg_ready);
		side_reg = side_word[SIDE_W-1:0];
		cfg_index <= CFG_CELL_SIZE;
		cfg_data <= size_word;
		do @(posedge clk); while (!cfg_ready);
		size_reg = size_word;
		register_writes += 2;
		if (with_spares) begin
			// unused indexes must leave both registers alone
			cfg_index <= CFG_SPARE_A;
			cfg_data <= 16'($urandom);
			do @(posedge clk); while (!cfg_ready);
			cfg_index <= CFG_SPARE_B;
			cfg_data <= 16'($urandom);
			do @(posedge clk); while (!cfg_ready);
			register_writes += 2;
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		sample_t want;
		if (m_tvalid && m_tready) begin
			if (expected_samples.size() == 0) begin
				$display("%0t ns: unexpected result word, cell %0h", $time, m_tdata[IDX_W-1:0]);
				errors++;
			end else begin
				want = expected_samples.pop_front();
				check_field("accepted", 32'(want.accepted), 32'(m_tuser));
				check_field("sample_cell", 32'(want.cell_id), 32'(m_tdata[IDX_W-1:0]));
				check_field("sample_x", 32'(want.x), 32'(m_tdata[IDX_W +: POS_W]));
				check_field("sample_y", 32'(want.y), 32'(m_tdata[IDX_W + POS_W +: POS_W]));
				check_field("accepted_count", 32'(want.count),
					32'(m_tdata[IDX_W + 2 * POS_W +: CNT_W]));
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= rx_mode_t'($urandom_range(3));
			stall_left <= $urandom_range(80, 4);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			RX_OPEN: m_tready <= 1'b1;
			RX_COIN: m_tready <= 1'($urandom_range(1));
			RX_SPARSE: m_tready <= ($urandom_range(9) == 0);
			default: m_tready <= (stall_left[1:0] != 2'd0);
		endcase
	end

	task automatic test_reset_defaults();
		offer_candidate(12'd0, 16'd0, 16'd0);
		offer_candidate(12'd0, 16'd10, 16'd10);
		offer_candidate(12'd1, 16'd0, 16'd0);
		offer_candidate(12'd64, 16'd0, 16'd255);
		pause_sender(5);
		offer_candidate(12'd128, 16'd0, 16'd0);
		offer_candidate(12'd4095, 16'hFFFF, 16'hFFFF);
		offer_candidate(12'd63, 16'd255, 16'd255);
		pause_sender(37);
		offer_candidate(12'd4032, 16'd0, 16'd0);
		drain_results();
	endtask

	task automatic test_small_grids();
		configure(16'd3, 16'd100, 1'b1);
		offer_candidate(12'd8, 16'd99, 16'd99);
		offer_candidate(12'd4, 16'd0, 16'd0);
		offer_candidate(12'd9, 16'd0, 16'd0);
		offer_candidate(12'd4095, 16'hFFFF, 16'hFFFF);
		drain_results();
		configure(16'd0, 16'd100, 1'b0);
		offer_candidate(12'd0, 16'd0, 16'd0);
		drain_results();
		configure(16'd100, 16'd256, 1'b0);
		offer_candidate(12'd4095, 16'd0, 16'd0);
		offer_candidate(12'd4000, 16'd1, 16'd1);
		drain_results();
		configure(16'hFF7F, 16'd256, 1'b0);
		offer_candidate(12'd1000, 16'd200, 16'd17);
		drain_results();
	endtask

	task automatic test_cell_size_extremes();
		configure(16'd64, 16'd0, 1'b0);
		offer_candidate(12'd200, 16'd0, 16'd0);
		offer_candidate(12'd201, 16'd0, 16'd0);
		offer_candidate(12'd200, 16'd5, 16'd5);
		drain_results();
		configure(16'd64, 16'hFFFF, 1'b0);
		offer_candidate(12'd2000, 16'hFFFF, 16'hFFFF);
		offer_candidate(12'd2001, 16'd0, 16'd0);
		offer_candidate(12'd2064, 16'h8000, 16'h0001);
		drain_results();
	endtask

	task automatic test_random_mix();
		logic [CFG_DATA_W-1:0] sides [10] = '{8, 16, 64, 5, 1, 70, 0, 64, 127, 32};
		logic [CFG_DATA_W-1:0] sizes [10] = '{256, 1, 65535, 4000, 300, 128, 256, 0, 30000, 1000};
		logic [CFG_DATA_W-1:0] side_word;
		logic [IDX_W-1:0] idx;
		logic [OFF_W-1:0] offx, offy;
		int side, ncells, sent, burst, pick, target;
		bit no_gaps;
		for (int p = 0; p < 10; p++) begin
			side_word = sides[p];
			if (p % 2 == 1)
				side_word = side_word | (16'($urandom_range(511)) << SIDE_W);
			configure(side_word, sizes[p], 1'b0);
			side = (sides[p] > GRID_MAX) ? GRID_MAX : int'(sides[p]);
			ncells = side * side;
			no_gaps = (p % 3 == 2);
			sent = 0;
			while (sent < 87) begin
				burst = $urandom_range(20, 1);
				for (int b = 0; b < burst; b++) begin
					pick = $urandom_range(99);
					if (pick < 5 || ncells == 0) begin
						idx = 12'($urandom);
					end else if (pick < 40) begin
						// aim at a neighbour of the last stored sample
						target = last_stored_cell + ($urandom_range(2) - 1) * side
							+ $urandom_range(2) - 1;
						if (target < 0)
							target = 0;
						if (target >= ncells)
							target = ncells - 1;
						idx = 12'(target);
					end else begin
						idx = 12'($urandom_range(ncells - 1));
					end
					if (sizes[p] == 0 || $urandom_range(9) == 0) begin
						offx = 16'($urandom);
						offy = 16'($urandom);
					end else begin
						offx = 16'($urandom_range(sizes[p] - 1));
						offy = 16'($urandom_range(sizes[p] - 1));
					end
					offer_candidate(idx, offx, offy);
					sent++;
				end
				pause_sender(no_gaps ? 0 : $urandom_range(40));
			end
			drain_results();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_small_grids();
		test_cell_size_extremes();
		test_random_mix();
		repeat (40) @(posedge clk);
		$display("ran %0d candidates: %0d stored, %0d out of range, rest rejected by spacing or own cell",
			candidates_sent, accepted_total, out_of_range_count);
		$display("%0d register writes, grid sides 0 to 127, cell sizes 0 to 65535", register_writes);
		if (errors == 0) begin
			$display("grid_poisson_disk_accept_top verification clean");
		end else begin
			$display("grid_poisson_disk_accept_top verification failed");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("timeout with %0d results outstanding", expected_samples.size());
		$display("grid_poisson_disk_accept_top verification failed");
		$finish;
	end

endmodule
